/* rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and defaults for the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package pse_pkg;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int CMD_W = 3;
    localparam int IO_W  = 32;
    localparam int ST_W  = 3;

    typedef enum logic [2:0] {
        CMD_NUMBER = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_SUB    = 3'd2,
        CMD_MUL    = 3'd3,
        CMD_DIV    = 3'd4,
        CMD_FINISH = 3'd5,
        CMD_UNK    = 3'd6,
        CMD_UNK7   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_CALC, S_WRITE, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV
    } t_op;

    // Arithmetic unit control
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;
endpackage
`default_nettype wire

/* rtl/pse_if.sv */
// ----------------------------------------------------------------------------
// pse_in_if / pse_out_if
// Valid/ready channels carrying tokens in and results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface pse_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic signed [31:0] operand_value;
    modport source (output valid, command, operand_value, input ready);
    modport sink   (input valid, command, operand_value, output ready);
endinterface

interface pse_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [2:0]  status;
    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

/* rtl/pse_alu.sv */
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: add/sub, shift-add multiply and
// restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pse_alu #(
    parameter int DATA_WIDTH = pse_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pse_pkg::t_alu_ctl     i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    output logic                       o_done,
    output logic [DATA_WIDTH-1:0]      o_res
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  r_busy, n_busy;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;   // product or remainder
    logic [DATA_WIDTH-1:0] r_sh, n_sh;     // multiplier / dividend-quotient
    logic [DATA_WIDTH-1:0] r_m, n_m;       // multiplicand / divisor magnitude
    logic                  r_neg, n_neg;
    logic                  r_div, n_div;
    logic                  r_done, n_done;
    logic [DATA_WIDTH-1:0] r_res, n_res;
    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH-1:0] w_ma, w_mb;

    assign w_ma = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_trial = {r_acc, r_sh[DATA_WIDTH-1]} - {1'b0, r_m};

    // Sequencing of one operation
    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_acc = r_acc; n_sh = r_sh; n_m = r_m;
        n_neg = r_neg; n_div = r_div; n_done = 1'b0; n_res = r_res;
        if (i_ctl.start) begin
            case (i_ctl.op)
                pse_pkg::OP_ADD: begin
                    n_res = i_a + i_b; n_done = 1'b1;
                end
                pse_pkg::OP_SUB: begin
                    n_res = i_a - i_b; n_done = 1'b1;
                end
                pse_pkg::OP_MUL: begin
                    n_busy = 1'b1; n_div = 1'b0; n_acc = '0; n_sh = i_b; n_m = i_a;
                    n_cnt = CW'(DATA_WIDTH);
                end
                default: begin
                    n_busy = 1'b1; n_div = 1'b1; n_acc = '0; n_sh = w_ma; n_m = w_mb;
                    n_neg = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                    n_cnt = CW'(DATA_WIDTH);
                end
            endcase
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[DATA_WIDTH]) begin
                    n_acc = w_trial[DATA_WIDTH-1:0];
                    n_sh = {r_sh[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[DATA_WIDTH-2:0], r_sh[DATA_WIDTH-1]};
                    n_sh = {r_sh[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                if (r_sh[0]) n_acc = r_acc + r_m;
                n_sh = r_sh >> 1;
                n_m = r_m << 1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
                if (r_div) n_res = r_neg ? (~n_sh + 1'b1) : n_sh;
                else n_res = n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_cnt <= n_cnt; r_acc <= n_acc; r_sh <= n_sh; r_m <= n_m;
        r_neg <= n_neg; r_div <= n_div; r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

/* rtl/postfix_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix token evaluator with an operand stack memory and a shared ALU.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_in    | in  | command[2:0], operand_value[31:0]
//  m_out   | out | result_value[31:0], status[2:0] (one beat per finish)
//
//  Number tokens push on acceptance. Operators pass RD_B, RD_A, EXEC, CALC,
//  WRITE; unknown ones skip CALC, a zero divisor ends at EXEC, and mul/div
//  wait in CALC on the bit-serial ALU. Finish skips RD_B if empty/errored.
//  Stack reads go through the registered memory port, one per cycle.
//  Reset clears count, error and handshake; the stack needs no clearing.
//  A result beat waiting on m_out.ready holds off every input token.
`default_nettype none
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = pse_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pse_in_if.sink     s_in,
    pse_out_if.source  m_out
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NW = $clog2(STACK_DEPTH + 1);

    pse_pkg::t_state r_state, n_state;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic [2:0]      r_err, n_err;
    logic [2:0]      r_cmd;
    logic [DATA_WIDTH-1:0] r_b, r_a, r_rd;
    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic            w_we;
    logic [AW-1:0]   w_wa, w_ra;
    logic [DATA_WIDTH-1:0] w_wd;
    logic            w_acc;
    pse_pkg::t_alu_ctl w_ctl;
    logic            w_done;
    logic [DATA_WIDTH-1:0] w_res;
    logic            r_ov, n_ov;
    logic [31:0]     r_ovv, n_ovv;
    logic [2:0]      r_ovs, n_ovs;
    logic [DATA_WIDTH-1:0] w_ext;

    assign w_acc = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == pse_pkg::S_IDLE) && !r_ov;
    assign w_ext = DATA_WIDTH'({{32{s_in.operand_value[31]}}, s_in.operand_value});

    // Stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rd <= mem[w_ra];
    end

    pse_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_a(r_a), .i_b(r_b), .o_done(w_done), .o_res(w_res)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pse_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (s_in.command == pse_pkg::CMD_FINISH) begin
                        n_state = (r_err == pse_pkg::ST_OK && r_cnt != '0)
                                  ? pse_pkg::S_RD_B : pse_pkg::S_FIN;
                    end else if (r_err == pse_pkg::ST_OK &&
                                 s_in.command != pse_pkg::CMD_NUMBER &&
                                 r_cnt >= NW'(2)) begin
                        n_state = pse_pkg::S_RD_B;
                    end
                end
            end
            pse_pkg::S_RD_B: n_state = (r_cmd == pse_pkg::CMD_FINISH)
                                       ? pse_pkg::S_FIN : pse_pkg::S_RD_A;
            pse_pkg::S_RD_A: n_state = pse_pkg::S_EXEC;
            pse_pkg::S_EXEC: begin
                if (r_cmd == pse_pkg::CMD_DIV && r_b == '0) n_state = pse_pkg::S_IDLE;
                else if (r_cmd == pse_pkg::CMD_UNK || r_cmd == pse_pkg::CMD_UNK7)
                    n_state = pse_pkg::S_WRITE;
                else n_state = pse_pkg::S_CALC;
            end
            pse_pkg::S_CALC:  if (w_done) n_state = pse_pkg::S_WRITE;
            pse_pkg::S_WRITE: n_state = pse_pkg::S_IDLE;
            pse_pkg::S_FIN:   n_state = pse_pkg::S_IDLE;
            default:          n_state = pse_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        n_cnt = r_cnt; n_err = r_err; w_we = 1'b0;
        w_wa = AW'(r_cnt - NW'(2)); w_wd = w_res;
        w_ra = AW'(r_cnt - NW'(1));
        w_ctl.start = 1'b0; w_ctl.op = pse_pkg::OP_ADD;
        n_ov = r_ov && !m_out.ready; n_ovv = r_ovv; n_ovs = r_ovs;
        case (r_state)
            pse_pkg::S_IDLE: begin
                if (w_acc && s_in.command != pse_pkg::CMD_FINISH &&
                    r_err == pse_pkg::ST_OK) begin
                    if (s_in.command == pse_pkg::CMD_NUMBER) begin
                        if (r_cnt >= NW'(STACK_DEPTH)) n_err = pse_pkg::ST_OVERFLOW;
                        else begin
                            w_we = 1'b1; w_wa = AW'(r_cnt); w_wd = w_ext;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (r_cnt < NW'(2)) n_err = pse_pkg::ST_FEW;
                end
            end
            pse_pkg::S_RD_B: w_ra = AW'(r_cnt - NW'(2));
            pse_pkg::S_EXEC: begin
                if (r_cmd == pse_pkg::CMD_DIV && r_b == '0) n_err = pse_pkg::ST_DIVZERO;
                else begin
                    w_ctl.start = !(r_cmd == pse_pkg::CMD_UNK || r_cmd == pse_pkg::CMD_UNK7);
                    case (r_cmd)
                        pse_pkg::CMD_ADD: w_ctl.op = pse_pkg::OP_ADD;
                        pse_pkg::CMD_SUB: w_ctl.op = pse_pkg::OP_SUB;
                        pse_pkg::CMD_MUL: w_ctl.op = pse_pkg::OP_MUL;
                        default:          w_ctl.op = pse_pkg::OP_DIV;
                    endcase
                end
            end
            pse_pkg::S_WRITE: begin
                w_we = 1'b1;
                w_wd = (r_cmd == pse_pkg::CMD_UNK || r_cmd == pse_pkg::CMD_UNK7)
                       ? '0 : w_res;
                n_cnt = r_cnt - 1'b1;
            end
            pse_pkg::S_FIN: begin
                n_ov = 1'b1;
                n_ovs = (r_err != pse_pkg::ST_OK) ? r_err :
                        (r_cnt == '0) ? 3'(pse_pkg::ST_EMPTY) : 3'(pse_pkg::ST_OK);
                n_ovv = (r_err == pse_pkg::ST_OK && r_cnt != '0)
                        ? 32'(r_b) : 32'd0;
                n_cnt = '0; n_err = pse_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pse_pkg::S_IDLE; r_cnt <= '0;
            r_err <= pse_pkg::ST_OK; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_err <= n_err; r_ov <= n_ov;
        end
        if (w_acc) r_cmd <= s_in.command;
        if (r_state == pse_pkg::S_RD_B) r_b <= r_rd;
        if (r_state == pse_pkg::S_RD_A) r_a <= r_rd;
        r_ovv <= n_ovv; r_ovs <= n_ovs;
    end

    assign m_out.valid = r_ov;
    assign m_out.result_value = r_ovv;
    assign m_out.status = r_ovs;
endmodule
`default_nettype wire

/* rtl/pse_checker.sv */
// ----------------------------------------------------------------------------
// pse_checker
// Port-level assertions for the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
module pse_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic [2:0] in_cmd,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [31:0] out_value,
    input wire logic [2:0] out_status
);
    // no result beat without an accepted finish token
    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && in_cmd == pse_pkg::CMD_FINISH, 3) ||
            $past(in_valid && in_ready && in_cmd == pse_pkg::CMD_FINISH, 2))
        else $error("spurious result");
    // errored result carries zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status != pse_pkg::ST_OK |-> out_value == 32'd0)
        else $error("nonzero value with error");
    // status codes stay in range
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status <= 3'd4) else $error("bad status");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result dropped");
    // not ready while a result waits
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("ready with result pending");
endmodule

bind postfix_stack_evaluator_top pse_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
    .in_cmd(s_in.command), .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_value(m_out.result_value), .out_status(m_out.status)
);
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix stack evaluator: directed token
// sequences for each operator and error path, then random expressions,
// each result checked against an in-bench model of the operand stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int DEPTH       = pse_pkg::STACK_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    pse_in_if  tok_if ();
    pse_out_if res_if ();

    postfix_stack_evaluator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (tok_if.sink),
        .m_out   (res_if.source)
    );

    // Model state
    logic [31:0]      mdl_stack [DEPTH];
    int               mdl_count;
    pse_pkg::t_status mdl_err;

    typedef struct {
        logic [31:0]      value;
        pse_pkg::t_status status;
    } t_result;
    t_result result_q[$];

    int  n_fail    = 0;
    int  n_results = 0;
    int  n_tokens  = 0;
    bit  rx_quiet  = 0;   // no idling in the closing part
    bit  tx_quiet  = 0;
    bit  rx_hold;         // long receiver hold-off in progress
    event hold_go;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Signed truncating divide at 32 bits; min / -1 wraps naturally
    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Advance the stack model by one token; queue a result on finish
    task automatic evaluate_token(pse_pkg::t_cmd cmd, logic [31:0] v);
        t_result     r;
        logic [31:0] a, b, y;
        if (cmd == pse_pkg::CMD_FINISH) begin
            r.value  = '0;
            r.status = mdl_err;
            if (mdl_err == pse_pkg::ST_OK) begin
                if (mdl_count == 0) r.status = pse_pkg::ST_EMPTY;
                else r.value = mdl_stack[mdl_count-1];
            end
            result_q.push_back(r);
            mdl_count = 0;
            mdl_err   = pse_pkg::ST_OK;
        end else if (mdl_err != pse_pkg::ST_OK) begin
        end else if (cmd == pse_pkg::CMD_NUMBER) begin
            if (mdl_count >= DEPTH) mdl_err = pse_pkg::ST_OVERFLOW;
            else begin
                mdl_stack[mdl_count] = v;
                mdl_count++;
            end
        end else if (mdl_count < 2) begin
            mdl_err = pse_pkg::ST_FEW;
        end else begin
            b = mdl_stack[mdl_count-1];
            a = mdl_stack[mdl_count-2];
            y = '0;
            case (cmd)
                pse_pkg::CMD_ADD: y = a + b;
                pse_pkg::CMD_SUB: y = a - b;
                pse_pkg::CMD_MUL: y = a * b;
                pse_pkg::CMD_DIV: y = (b == 0) ? '0 : div_trunc(a, b);
                default:          y = '0;
            endcase
            if (cmd == pse_pkg::CMD_DIV && b == 0) mdl_err = pse_pkg::ST_DIVZERO;
            else begin
                mdl_count--;
                mdl_stack[mdl_count-1] = y;
            end
        end
    endtask

    // Send one token, with optional random idle burst first; valid stays up
    // after the beat so that back-to-back tokens need one assignment a step
    task automatic send_token(pse_pkg::t_cmd cmd, logic [31:0] v);
        if (!tx_quiet && $urandom_range(0, 5) == 0) begin
            tok_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        tok_if.valid         <= 1'b1;
        tok_if.command       <= cmd;
        tok_if.operand_value <= v;
        do @(posedge i_clk); while (!tok_if.ready);
        evaluate_token(cmd, v);
        n_tokens++;
    endtask

    task automatic push(logic [31:0] v);
        send_token(pse_pkg::CMD_NUMBER, v);
    endtask

    // Long receiver hold-off, counted in cycles
    initial forever begin
        @(hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Receiver readiness: random bursts, held off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else if (rx_hold) res_if.ready <= 1'b0;
        else if (rx_quiet) res_if.ready <= 1'b1;
        else res_if.ready <= ($urandom_range(0, 3) != 0);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (result_q.size() == 0) begin
                $error("unexpected result beat value=%0h status=%0d",
                       res_if.result_value, res_if.status);
                n_fail++;
            end else begin
                e = result_q.pop_front();
                if (res_if.result_value !== e.value) begin
                    $error("result_value exp=%0h act=%0h", e.value, res_if.result_value);
                    n_fail++;
                end
                if (res_if.status !== e.status) begin
                    $error("status exp=%0d act=%0d", e.status, res_if.status);
                    n_fail++;
                end
            end
        end
    end

    task automatic test_arith;
        push(32'd7); push(32'd5); send_token(pse_pkg::CMD_ADD, 0);
        send_token(pse_pkg::CMD_FINISH, 0);
        push(32'h8000_0000); push(32'd1); send_token(pse_pkg::CMD_SUB, 0);
        send_token(pse_pkg::CMD_FINISH, 0);
        push(32'h7fff_ffff); push(32'hffff_ffff); send_token(pse_pkg::CMD_MUL, 0);
        send_token(pse_pkg::CMD_FINISH, 0);
        push(-32'sd7); push(32'd2); send_token(pse_pkg::CMD_DIV, 32'hffff_ffff);
        send_token(pse_pkg::CMD_FINISH, 0);
        // most negative over minus one wraps
        push(32'h8000_0000); push(32'hffff_ffff); send_token(pse_pkg::CMD_DIV, 0);
        send_token(pse_pkg::CMD_FINISH, 0);
        push(32'd3); push(32'd4); send_token(pse_pkg::CMD_UNK, 0);
        send_token(pse_pkg::CMD_FINISH, 0);
        push(32'd3); push(32'd4); send_token(pse_pkg::CMD_UNK7, 0); push(32'd9);
        send_token(pse_pkg::CMD_FINISH, 0);
    endtask

    task automatic test_errors;
        send_token(pse_pkg::CMD_FINISH, 0);                      // empty
        push(32'd1); send_token(pse_pkg::CMD_ADD, 0); push(32'd2);
        send_token(pse_pkg::CMD_FINISH, 0);                      // too few
        push(32'd1); push(32'd0); send_token(pse_pkg::CMD_DIV, 0);
        send_token(pse_pkg::CMD_FINISH, 0);
        for (int i = 0; i <= DEPTH; i++) push($urandom);         // overflow
        send_token(pse_pkg::CMD_FINISH, 0);
        for (int i = 0; i < DEPTH; i++) push($urandom);          // exactly full
        send_token(pse_pkg::CMD_FINISH, 0);
    endtask

    // Long receiver stall while finishes keep coming
    task automatic test_backpressure;
        -> hold_go;
        repeat (6) begin
            push($urandom); send_token(pse_pkg::CMD_FINISH, 0);
        end
    endtask

    // Well-formed random expressions, with some noise
    task automatic test_random(int n_items);
        int            sent;
        int            depth;
        pse_pkg::t_cmd op;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                op = pse_pkg::t_cmd'($urandom_range(0, 7));
                send_token(op, $urandom);
                sent++;
            end else begin
                depth = 0;
                repeat ($urandom_range(1, 12)) begin
                    if (depth < 2 || (depth < DEPTH && $urandom_range(0, 1))) begin
                        case ($urandom_range(0, 3))
                            0: push($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
                            1: push($urandom_range(0, 20) - 10);
                            default: push($urandom);
                        endcase
                        depth++;
                    end else begin
                        op = pse_pkg::t_cmd'($urandom_range(1, 7));
                        if (op == pse_pkg::CMD_FINISH) op = pse_pkg::CMD_DIV;
                        send_token(op, $urandom);
                        depth--;
                    end
                    sent++;
                end
                send_token(pse_pkg::CMD_FINISH, 0);
                sent++;
            end
        end
    endtask

    initial begin
        tok_if.valid         <= 1'b0;
        tok_if.command       <= pse_pkg::CMD_NUMBER;
        tok_if.operand_value <= '0;
        mdl_count = 0;
        mdl_err   = pse_pkg::ST_OK;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_arith();
        test_errors();
        test_backpressure();
        test_random(800);
        tx_quiet = 1;
        rx_quiet = 1;
        test_random(280);
        tok_if.valid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("tb: %0d tokens driven, %0d results checked", n_tokens, n_results);
        $display("tb: covered all operators, every error code, overflow and stalls");
        if (n_fail == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
